/* rtl/tftprd_pkg.sv */
// Shared types and codes for the TFTP read-transfer sender.
// Used by every module of the block; depends on nothing.
`default_nettype none
package tftprd_pkg;

   // Request commands.
   localparam logic [1:0] CMD_START  = 2'd0;
   localparam logic [1:0] CMD_ACK    = 2'd1;
   localparam logic [1:0] CMD_DATA   = 2'd2;
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   // Result actions.
   localparam logic [1:0] ACT_NONE  = 2'd0;
   localparam logic [1:0] ACT_DATA  = 2'd1;
   localparam logic [1:0] ACT_OACK  = 2'd2;
   localparam logic [1:0] ACT_ERROR = 2'd3;

   // Error codes.
   localparam logic [1:0] ERR_NONE    = 2'd0;
   localparam logic [1:0] ERR_REFUSED = 2'd1;
   localparam logic [1:0] ERR_ILLEGAL = 2'd2;

   // Transfer status codes.
   localparam logic [1:0] STATUS_RUN = 2'd0;
   localparam logic [1:0] STATUS_OK  = 2'd1;
   localparam logic [1:0] STATUS_ERR = 2'd2;

   // Configuration register indexes.
   localparam logic [1:0] REG_MAX_BLOCK_SIZE     = 2'd0;
   localparam logic [1:0] REG_TIMEOUT_LIMIT      = 2'd1;
   localparam logic [1:0] REG_TSIZE_ENABLE       = 2'd2;
   localparam logic [1:0] REG_DEFAULT_BLOCK_SIZE = 2'd3;

   localparam logic [15:0] DEFAULT_BLOCK_SIZE_RESET = 16'd512;
   localparam logic [15:0] BLOCK_ALL_ONES           = 16'hFFFF;

   typedef struct packed {
      logic [15:0] max_block_size;
      logic [7:0]  timeout_limit;
      logic        tsize_enable;
      logic [15:0] default_block_size;
   } cfg_type;

   // How a start request is answered.
   typedef enum logic [1:0] {
      KIND_DATA,
      KIND_OACK,
      KIND_REFUSE
   } kind_type;

   // One classified request as it waits between front and back.
   typedef struct packed {
      logic [1:0]  command;
      logic [15:0] ack_block;
      logic [15:0] chunk_length;
      kind_type    kind;
      logic [15:0] blk_size;
      logic [15:0] oack_blksize;
      logic [7:0]  oack_timeout;
      logic        oack_tsize_included;
      logic [31:0] oack_tsize;
   } entry_type;

endpackage
`default_nettype wire

/* rtl/tftprd_csr.sv */
// Configuration registers behind an APB-style port.
// Depends on tftprd_pkg for the register indexes and the cfg_type bundle.
`default_nettype none
module tftprd_csr (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             csr_psel,
   input  wire logic             csr_penable,
   input  wire logic             csr_pwrite,
   input  wire logic [3:0]       csr_paddr,
   input  wire logic [31:0]      csr_pwdata,
   output logic      [31:0]      csr_prdata,
   output logic                  csr_pready,
   output tftprd_pkg::cfg_type   cfg
);
   import tftprd_pkg::*;

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic [1:0] reg_index;
   logic       wr_en;

   assign reg_index  = csr_paddr[3:2];
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_index)
            REG_MAX_BLOCK_SIZE:     cfg_in.max_block_size     = csr_pwdata[15:0];
            REG_TIMEOUT_LIMIT:      cfg_in.timeout_limit      = csr_pwdata[7:0];
            REG_TSIZE_ENABLE:       cfg_in.tsize_enable       = csr_pwdata[0];
            REG_DEFAULT_BLOCK_SIZE: cfg_in.default_block_size = csr_pwdata[15:0];
            default:                cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_index)
         REG_MAX_BLOCK_SIZE:     csr_prdata = {16'd0, cfg_ff.max_block_size};
         REG_TIMEOUT_LIMIT:      csr_prdata = {24'd0, cfg_ff.timeout_limit};
         REG_TSIZE_ENABLE:       csr_prdata = {31'd0, cfg_ff.tsize_enable};
         REG_DEFAULT_BLOCK_SIZE: csr_prdata = {16'd0, cfg_ff.default_block_size};
         default:                csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_block_size     <= 16'd0;
         cfg_ff.timeout_limit      <= 8'd0;
         cfg_ff.tsize_enable       <= 1'b0;
         cfg_ff.default_block_size <= DEFAULT_BLOCK_SIZE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule
`default_nettype wire

/* rtl/tftprd_front.sv */
// Front end: accepts requests and negotiates the options of a start request.
// Depends on tftprd_pkg; its output is written into tftprd_queue.
`default_nettype none
module tftprd_front (
   input  wire logic                 req_valid,
   input  wire logic [1:0]           req_command,
   input  wire logic [15:0]          req_ack_block,
   input  wire logic [15:0]          req_chunk_length,
   input  wire logic [15:0]          req_client_blksize,
   input  wire logic [7:0]           req_client_timeout,
   input  wire logic                 req_client_tsize_present,
   input  wire logic                 req_client_tsize_nonzero,
   input  wire logic                 req_extra_options,
   input  wire logic                 req_file_size_known,
   input  wire logic [31:0]          req_file_size,
   input  tftprd_pkg::cfg_type       cfg,
   input  wire logic                 queue_full,
   output logic                      push,
   output tftprd_pkg::entry_type     entry
);
   import tftprd_pkg::*;

   logic        plain;
   logic        blk_ok;
   logic        tmo_ok;
   logic        tsize_chk;
   logic [15:0] neg_blk;

   assign push = req_valid & ~queue_full;

   // A start request without any option gets data block 1 straight away.
   assign plain = (req_client_blksize == 16'd0) && (req_client_timeout == 8'd0) &&
                  !req_client_tsize_present && !req_extra_options;
   assign blk_ok = (cfg.max_block_size != 16'd0) && (req_client_blksize != 16'd0);
   assign tmo_ok = (cfg.timeout_limit != 8'd0) && (req_client_timeout != 8'd0) &&
                   (req_client_timeout <= cfg.timeout_limit);
   assign tsize_chk = cfg.tsize_enable & req_client_tsize_present;
   assign neg_blk = (req_client_blksize < cfg.max_block_size) ?
                    req_client_blksize : cfg.max_block_size;

   always_comb begin
      entry.command             = req_command;
      entry.ack_block           = req_ack_block;
      entry.chunk_length        = req_chunk_length;
      entry.kind                = KIND_DATA;
      entry.blk_size            = cfg.default_block_size;
      entry.oack_blksize        = 16'd0;
      entry.oack_timeout        = 8'd0;
      entry.oack_tsize_included = 1'b0;
      entry.oack_tsize          = 32'd0;
      if (!plain) begin
         if (blk_ok) begin
            entry.blk_size     = neg_blk;
            entry.oack_blksize = neg_blk;
         end
         if (tmo_ok) begin
            entry.oack_timeout = req_client_timeout;
         end
         if (tsize_chk && req_file_size_known && !req_client_tsize_nonzero) begin
            entry.oack_tsize_included = 1'b1;
            entry.oack_tsize          = req_file_size;
         end
         if (tsize_chk && req_client_tsize_nonzero) begin
            // With tsize enabled, a nonzero tsize from the client is refused; nothing is offered.
            entry.kind         = KIND_REFUSE;
            entry.oack_blksize = 16'd0;
            entry.oack_timeout = 8'd0;
         end else if (req_extra_options || blk_ok || tmo_ok ||
                      entry.oack_tsize_included) begin
            entry.kind = KIND_OACK;
         end
      end
   end

endmodule
`default_nettype wire

/* rtl/tftprd_queue.sv */
// Two-entry queue of classified requests between the front and back ends.
// Depends on tftprd_pkg for entry_type.
`default_nettype none
module tftprd_queue (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push,
   input  tftprd_pkg::entry_type     push_entry,
   input  wire logic                 pop,
   output logic                      full,
   output logic                      not_empty,
   output tftprd_pkg::entry_type     head
);
   import tftprd_pkg::*;

   entry_type  slot_ff [2];
   logic       wr_ptr_ff;
   logic       wr_ptr_in;
   logic       rd_ptr_ff;
   logic       rd_ptr_in;
   logic [1:0] count_ff;
   logic [1:0] count_in;

   assign full      = (count_ff == 2'd2);
   assign not_empty = (count_ff != 2'd0);
   assign head      = slot_ff[rd_ptr_ff];

   assign wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
   assign rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule
`default_nettype wire

/* rtl/tftprd_back.sv */
// Back end: holds the transfer state, acts on each queued request and
// registers the result. Depends on tftprd_pkg.
`default_nettype none
module tftprd_back (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 q_valid,
   input  tftprd_pkg::entry_type     q_entry,
   output logic                      pop,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output logic [1:0]                rsp_action,
   output logic [15:0]               rsp_data_block,
   output logic [15:0]               rsp_data_length,
   output logic [1:0]                rsp_error_code,
   output logic [1:0]                rsp_status,
   output logic [15:0]               rsp_oack_blksize,
   output logic [7:0]                rsp_oack_timeout,
   output logic                      rsp_oack_tsize_included,
   output logic [31:0]               rsp_oack_tsize
);
   import tftprd_pkg::*;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_RUN,
      PH_OK,
      PH_ERR
   } phase_type;

   phase_type   phase_ff,      phase_in;
   logic [15:0] sent_ff,       sent_in;
   logic [15:0] acked_ff,      acked_in;
   logic        last_ff,       last_in;
   logic [15:0] bsize_ff,      bsize_in;
   logic        valid_ff,      valid_in;
   logic [1:0]  action_ff,     action_in;
   logic [15:0] dblock_ff,     dblock_in;
   logic [15:0] dlen_ff,       dlen_in;
   logic [1:0]  err_ff,        err_in;
   logic [1:0]  status_ff,     status_in;
   logic [15:0] oblk_ff,       oblk_in;
   logic [7:0]  otmo_ff,       otmo_in;
   logic        otsi_ff,       otsi_in;
   logic [31:0] otsize_ff,     otsize_in;

   logic [15:0] use_bsize;
   logic [15:0] next_block;
   logic        short_blk;
   logic [15:0] blk_len;

   // The result register is free when empty or being taken this cycle.
   assign pop = q_valid & (~valid_ff | ~rsp_stall);

   // A start uses its negotiated size; an ACK uses the one of the transfer.
   assign use_bsize  = (q_entry.command == CMD_START) ? q_entry.blk_size : bsize_ff;
   assign next_block = (q_entry.command == CMD_START) ? 16'd1 : sent_ff + 16'd1;
   assign short_blk  = q_entry.chunk_length < use_bsize;
   assign blk_len    = short_blk ? q_entry.chunk_length : use_bsize;

   always_comb begin
      phase_in  = phase_ff;
      sent_in   = sent_ff;
      acked_in  = acked_ff;
      last_in   = last_ff;
      bsize_in  = bsize_ff;
      valid_in  = valid_ff & rsp_stall;
      action_in = action_ff;
      dblock_in = dblock_ff;
      dlen_in   = dlen_ff;
      err_in    = err_ff;
      status_in = status_ff;
      oblk_in   = oblk_ff;
      otmo_in   = otmo_ff;
      otsi_in   = otsi_ff;
      otsize_in = otsize_ff;
      if (pop) begin
         valid_in  = 1'b1;
         action_in = ACT_NONE;
         dblock_in = 16'd0;
         dlen_in   = 16'd0;
         err_in    = ERR_NONE;
         status_in = STATUS_RUN;
         oblk_in   = 16'd0;
         otmo_in   = 8'd0;
         otsi_in   = 1'b0;
         otsize_in = 32'd0;
         if (q_entry.command == CMD_START) begin
            phase_in = PH_RUN;
            sent_in  = 16'd0;
            acked_in = 16'd0;
            last_in  = 1'b0;
            bsize_in = q_entry.blk_size;
            case (q_entry.kind)
               KIND_OACK: begin
                  // The client's ACK 0 must not look like a repeat.
                  acked_in  = BLOCK_ALL_ONES;
                  action_in = ACT_OACK;
                  oblk_in   = q_entry.oack_blksize;
                  otmo_in   = q_entry.oack_timeout;
                  otsi_in   = q_entry.oack_tsize_included;
                  otsize_in = q_entry.oack_tsize;
               end
               KIND_REFUSE: begin
                  phase_in  = PH_ERR;
                  action_in = ACT_ERROR;
                  err_in    = ERR_REFUSED;
                  status_in = STATUS_ERR;
               end
               default: begin
                  sent_in   = next_block;
                  last_in   = short_blk;
                  action_in = ACT_DATA;
                  dblock_in = next_block;
                  dlen_in   = blk_len;
               end
            endcase
         end else if (phase_ff != PH_RUN || q_entry.command == CMD_UNUSED) begin
            case (phase_ff)
               PH_OK:   status_in = STATUS_OK;
               PH_ERR:  status_in = STATUS_ERR;
               default: status_in = STATUS_RUN;
            endcase
         end else if (q_entry.command == CMD_DATA) begin
            phase_in  = PH_ERR;
            action_in = ACT_ERROR;
            err_in    = ERR_ILLEGAL;
            status_in = STATUS_ERR;
         end else if (q_entry.ack_block == acked_ff) begin
            status_in = STATUS_RUN;
         end else if (q_entry.ack_block != sent_ff) begin
            phase_in  = PH_ERR;
            action_in = ACT_ERROR;
            err_in    = ERR_ILLEGAL;
            status_in = STATUS_ERR;
         end else if (last_ff) begin
            acked_in  = q_entry.ack_block;
            phase_in  = PH_OK;
            status_in = STATUS_OK;
         end else begin
            acked_in  = q_entry.ack_block;
            sent_in   = next_block;
            last_in   = short_blk;
            action_in = ACT_DATA;
            dblock_in = next_block;
            dlen_in   = blk_len;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         sent_ff  <= 16'd0;
         acked_ff <= 16'd0;
         last_ff  <= 1'b0;
         bsize_ff <= DEFAULT_BLOCK_SIZE_RESET;
         valid_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         sent_ff  <= sent_in;
         acked_ff <= acked_in;
         last_ff  <= last_in;
         bsize_ff <= bsize_in;
         valid_ff <= valid_in;
      end
      action_ff <= action_in;
      dblock_ff <= dblock_in;
      dlen_ff   <= dlen_in;
      err_ff    <= err_in;
      status_ff <= status_in;
      oblk_ff   <= oblk_in;
      otmo_ff   <= otmo_in;
      otsi_ff   <= otsi_in;
      otsize_ff <= otsize_in;
   end

   assign rsp_valid               = valid_ff;
   assign rsp_action              = action_ff;
   assign rsp_data_block          = dblock_ff;
   assign rsp_data_length         = dlen_ff;
   assign rsp_error_code          = err_ff;
   assign rsp_status              = status_ff;
   assign rsp_oack_blksize        = oblk_ff;
   assign rsp_oack_timeout        = otmo_ff;
   assign rsp_oack_tsize_included = otsi_ff;
   assign rsp_oack_tsize          = otsize_ff;

endmodule
`default_nettype wire

/* rtl/tftp_read_transfer_sender.sv */
// Top level of the TFTP read-transfer sender, server side.
// Instantiates tftprd_csr, tftprd_front, tftprd_queue and tftprd_back.
//
// Each request (start, ACK received, DATA received) on the req_ channel gives
// exactly one result on the rsp_ channel: DATA, OACK, ERROR or nothing, with
// the transfer status. Both channels use valid/stall; a request is taken when
// req_valid is high and req_stall low, a result likewise on rsp_.
// The front end negotiates the options of a start request in the cycle of
// acceptance and writes the request into a two-entry queue; the back end then
// updates the transfer state and registers the result, so a request passes a
// queue entry and the result register on its way to rsp_. Throughput is one
// request per cycle while the receiver does not stall.
// When the receiver stalls, the result register holds, the queue fills and
// req_stall rises once both queue entries are occupied.
// The csr_ port holds max_block_size, timeout_limit, tsize_enable and
// default_block_size at byte addresses 0, 4, 8 and 12; write it only while idle.
// Reset empties the queue and the result register and clears the transfer state; the
// registers return to zero, except default_block_size, which returns to 512.
`default_nettype none
module tftp_read_transfer_sender (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_command,
   input  wire logic [15:0] req_ack_block,
   input  wire logic [15:0] req_chunk_length,
   input  wire logic [15:0] req_client_blksize,
   input  wire logic [7:0]  req_client_timeout,
   input  wire logic        req_client_tsize_present,
   input  wire logic        req_client_tsize_nonzero,
   input  wire logic        req_extra_options,
   input  wire logic        req_file_size_known,
   input  wire logic [31:0] req_file_size,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [1:0]       rsp_action,
   output logic [15:0]      rsp_data_block,
   output logic [15:0]      rsp_data_length,
   output logic [1:0]       rsp_error_code,
   output logic [1:0]       rsp_status,
   output logic [15:0]      rsp_oack_blksize,
   output logic [7:0]       rsp_oack_timeout,
   output logic             rsp_oack_tsize_included,
   output logic [31:0]      rsp_oack_tsize,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [3:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);
   import tftprd_pkg::*;

   cfg_type   cfg;
   entry_type push_entry;
   entry_type head;
   logic      push;
   logic      pop;
   logic      full;
   logic      not_empty;

   assign req_stall = full;

   tftprd_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   tftprd_front u_front (
      .req_valid                (req_valid),
      .req_command              (req_command),
      .req_ack_block            (req_ack_block),
      .req_chunk_length         (req_chunk_length),
      .req_client_blksize       (req_client_blksize),
      .req_client_timeout       (req_client_timeout),
      .req_client_tsize_present (req_client_tsize_present),
      .req_client_tsize_nonzero (req_client_tsize_nonzero),
      .req_extra_options        (req_extra_options),
      .req_file_size_known      (req_file_size_known),
      .req_file_size            (req_file_size),
      .cfg                      (cfg),
      .queue_full               (full),
      .push                     (push),
      .entry                    (push_entry)
   );

   tftprd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .full       (full),
      .not_empty  (not_empty),
      .head       (head)
   );

   tftprd_back u_back (
      .clock                   (clock),
      .reset                   (reset),
      .q_valid                 (not_empty),
      .q_entry                 (head),
      .pop                     (pop),
      .rsp_valid               (rsp_valid),
      .rsp_stall               (rsp_stall),
      .rsp_action              (rsp_action),
      .rsp_data_block          (rsp_data_block),
      .rsp_data_length         (rsp_data_length),
      .rsp_error_code          (rsp_error_code),
      .rsp_status              (rsp_status),
      .rsp_oack_blksize        (rsp_oack_blksize),
      .rsp_oack_timeout        (rsp_oack_timeout),
      .rsp_oack_tsize_included (rsp_oack_tsize_included),
      .rsp_oack_tsize          (rsp_oack_tsize)
   );

endmodule
`default_nettype wire

/* sim/testbench.sv */
// Self-checking testbench for tftp_read_transfer_sender: drives requests, predicts every
// result and compares each one as it leaves the block. Depends on rtl/tftprd_pkg.sv and
// rtl/tftp_read_transfer_sender.sv.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import tftprd_pkg::*;

   localparam logic [15:0] CHUNK_MAX   = 16'd65464;
   localparam int          IDLE_LIMIT  = 3000;
   localparam int          PRINT_LIMIT = 40;

   typedef enum logic [1:0] {PHASE_IDLE, PHASE_RUN, PHASE_OK, PHASE_ERR} xfer_phase_type;

   typedef struct packed {
      logic [1:0]  command;
      logic [15:0] ack_block;
      logic [15:0] chunk_length;
      logic [15:0] client_blksize;
      logic [7:0]  client_timeout;
      logic        tsize_present;
      logic        tsize_nonzero;
      logic        extra_options;
      logic        size_known;
      logic [31:0] file_size;
   } request_type;

   typedef struct packed {
      logic [1:0]  action;
      logic [15:0] data_block;
      logic [15:0] data_length;
      logic [1:0]  error_code;
      logic [1:0]  status;
      logic [15:0] oack_blksize;
      logic [7:0]  oack_timeout;
      logic        oack_tsize_included;
      logic [31:0] oack_tsize;
   } packet_type;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   request_type req_item = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_action;
   logic [15:0] rsp_data_block;
   logic [15:0] rsp_data_length;
   logic [1:0]  rsp_error_code;
   logic [1:0]  rsp_status;
   logic [15:0] rsp_oack_blksize;
   logic [7:0]  rsp_oack_timeout;
   logic        rsp_oack_tsize_included;
   logic [31:0] rsp_oack_tsize;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [3:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   tftp_read_transfer_sender DUT (
      .clock                    (clock),
      .reset                    (reset),
      .req_valid                (req_valid),
      .req_stall                (req_stall),
      .req_command              (req_item.command),
      .req_ack_block            (req_item.ack_block),
      .req_chunk_length         (req_item.chunk_length),
      .req_client_blksize       (req_item.client_blksize),
      .req_client_timeout       (req_item.client_timeout),
      .req_client_tsize_present (req_item.tsize_present),
      .req_client_tsize_nonzero (req_item.tsize_nonzero),
      .req_extra_options        (req_item.extra_options),
      .req_file_size_known      (req_item.size_known),
      .req_file_size            (req_item.file_size),
      .rsp_valid                (rsp_valid),
      .rsp_stall                (rsp_stall),
      .rsp_action               (rsp_action),
      .rsp_data_block           (rsp_data_block),
      .rsp_data_length          (rsp_data_length),
      .rsp_error_code           (rsp_error_code),
      .rsp_status               (rsp_status),
      .rsp_oack_blksize         (rsp_oack_blksize),
      .rsp_oack_timeout         (rsp_oack_timeout),
      .rsp_oack_tsize_included  (rsp_oack_tsize_included),
      .rsp_oack_tsize           (rsp_oack_tsize),
      .csr_psel                 (csr_psel),
      .csr_penable              (csr_penable),
      .csr_pwrite               (csr_pwrite),
      .csr_paddr                (csr_paddr),
      .csr_pwdata               (csr_pwdata),
      .csr_prdata               (csr_prdata),
      .csr_pready               (csr_pready)
   );

   // Transfer state as the block should hold it, and the registers as last written.
   cfg_type        cfg_shadow = '{max_block_size: 16'd0, timeout_limit: 8'd0,
                                  tsize_enable: 1'b0,
                                  default_block_size: DEFAULT_BLOCK_SIZE_RESET};
   xfer_phase_type xfer_phase = PHASE_IDLE;
   logic [15:0]    sent_blk = '0;
   logic [15:0]    acked_blk = '0;
   logic           last_block_sent = 1'b0;
   logic [15:0]    cur_block_size = DEFAULT_BLOCK_SIZE_RESET;

   request_type request_backlog[$];
   packet_type  awaited_packets[$];
   int          pending_requests = 0;
   int          queued_total = 0;
   int          mismatch_count = 0;
   int          idle_cycles = 0;
   bit          req_taken = 1'b0;

   int          burst_left = 1;
   int          gap_left = 0;
   bit          drain_hold = 1'b0;
   int          stall_mode = 0;
   int          stall_left = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      mismatch_count++;
      if (mismatch_count <= PRINT_LIMIT)
         $display("mismatch at %0t: %s, got %0h, want %0h", $time, what, got, want);
   endtask

   function automatic void send_block(input logic [15:0] chunk, inout packet_type p);
      logic [15:0] len;
      sent_blk = sent_blk + 16'd1;
      len = (chunk < cur_block_size) ? chunk : cur_block_size;
      if (len < cur_block_size) last_block_sent = 1'b1;
      p.action = ACT_DATA;
      p.data_block = sent_blk;
      p.data_length = len;
   endfunction

   function automatic void end_in_error(input logic [1:0] code, inout packet_type p);
      xfer_phase = PHASE_ERR;
      p.action = ACT_ERROR;
      p.error_code = code;
      p.status = STATUS_ERR;
   endfunction

   // The packet the block sends in answer to one request; advances the transfer state.
   function automatic packet_type answer_for(input request_type r);
      packet_type p;
      logic       any;
      p = '0;
      if (r.command == CMD_START) begin
         xfer_phase = PHASE_RUN;
         sent_blk = '0;
         acked_blk = '0;
         last_block_sent = 1'b0;
         cur_block_size = cfg_shadow.default_block_size;
         if (r.client_blksize == 0 && r.client_timeout == 0 && !r.tsize_present &&
             !r.extra_options) begin
            send_block(r.chunk_length, p);
            return p;
         end
         any = r.extra_options;
         if (cfg_shadow.max_block_size != 0 && r.client_blksize != 0) begin
            cur_block_size = (r.client_blksize < cfg_shadow.max_block_size) ?
                             r.client_blksize : cfg_shadow.max_block_size;
            p.oack_blksize = cur_block_size;
            any = 1'b1;
         end
         if (cfg_shadow.timeout_limit != 0 && r.client_timeout != 0 &&
             r.client_timeout <= cfg_shadow.timeout_limit) begin
            p.oack_timeout = r.client_timeout;
            any = 1'b1;
         end
         if (cfg_shadow.tsize_enable && r.tsize_present) begin
            if (r.tsize_nonzero) begin
               // A refused option drops everything negotiated so far.
               p = '0;
               end_in_error(ERR_REFUSED, p);
               return p;
            end
            if (r.size_known) begin
               p.oack_tsize_included = 1'b1;
               p.oack_tsize = r.file_size;
               any = 1'b1;
            end
         end
         if (any) begin
            // The client's ACK 0 must not look like a repeat.
            acked_blk = BLOCK_ALL_ONES;
            p.action = ACT_OACK;
         end else begin
            send_block(r.chunk_length, p);
         end
         return p;
      end
      if (xfer_phase != PHASE_RUN || r.command == CMD_UNUSED) begin
         if (xfer_phase == PHASE_OK) p.status = STATUS_OK;
         else if (xfer_phase == PHASE_ERR) p.status = STATUS_ERR;
         return p;
      end
      if (r.command == CMD_DATA) begin
         end_in_error(ERR_ILLEGAL, p);
         return p;
      end
      if (r.ack_block == acked_blk) return p;
      if (r.ack_block != sent_blk) begin
         end_in_error(ERR_ILLEGAL, p);
         return p;
      end
      acked_blk = r.ack_block;
      if (last_block_sent) begin
         xfer_phase = PHASE_OK;
         p.status = STATUS_OK;
         return p;
      end
      send_block(r.chunk_length, p);
      return p;
   endfunction

   task automatic check_packet(input packet_type got, input packet_type want);
      if (got.action !== want.action) report_mismatch("action", got.action, want.action);
      if (got.data_block !== want.data_block)
         report_mismatch("data_block", got.data_block, want.data_block);
      if (got.data_length !== want.data_length)
         report_mismatch("data_length", got.data_length, want.data_length);
      if (got.error_code !== want.error_code)
         report_mismatch("error_code", got.error_code, want.error_code);
      if (got.status !== want.status) report_mismatch("status", got.status, want.status);
      if (got.oack_blksize !== want.oack_blksize)
         report_mismatch("oack_blksize", got.oack_blksize, want.oack_blksize);
      if (got.oack_timeout !== want.oack_timeout)
         report_mismatch("oack_timeout", got.oack_timeout, want.oack_timeout);
      if (got.oack_tsize_included !== want.oack_tsize_included)
         report_mismatch("oack_tsize_included", got.oack_tsize_included,
                         want.oack_tsize_included);
      if (got.oack_tsize !== want.oack_tsize)
         report_mismatch("oack_tsize", got.oack_tsize, want.oack_tsize);
   endtask

   // Both handshakes are judged here, on values that settled at the falling edge.
   always @(posedge clock) begin
      packet_type seen;
      if (!reset) begin
         idle_cycles++;
         if (req_valid && !req_stall) begin
            awaited_packets.push_back(answer_for(req_item));
            pending_requests--;
            req_taken = 1'b1;
            idle_cycles = 0;
         end
         if (rsp_valid && !rsp_stall) begin
            idle_cycles = 0;
            seen.action = rsp_action;
            seen.data_block = rsp_data_block;
            seen.data_length = rsp_data_length;
            seen.error_code = rsp_error_code;
            seen.status = rsp_status;
            seen.oack_blksize = rsp_oack_blksize;
            seen.oack_timeout = rsp_oack_timeout;
            seen.oack_tsize_included = rsp_oack_tsize_included;
            seen.oack_tsize = rsp_oack_tsize;
            if (awaited_packets.size() == 0)
               report_mismatch("result with nothing outstanding", rsp_action, 0);
            else
               check_packet(seen, awaited_packets.pop_front());
         end
      end
   end

   // Sender: bursts of requests separated by gaps, now and then holding back until the
   // block has answered everything.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         req_taken = 1'b0;
         if (drain_hold) begin
            if (awaited_packets.size() == 0) drain_hold = 1'b0;
            req_valid <= 1'b0;
         end else if (gap_left != 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (request_backlog.size() != 0) begin
            req_item <= request_backlog.pop_front();
            req_valid <= 1'b1;
            if (burst_left > 1) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(1, 20);
               case ($urandom_range(0, 3))
                  0, 1: gap_left = 0;
                  2: gap_left = $urandom_range(1, 4);
                  default: gap_left = $urandom_range(5, 25);
               endcase
               drain_hold = ($urandom_range(0, 9) == 0);
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver: stretches of no stalling, light stalling and heavy stalling.
   always @(negedge clock) begin
      if (stall_left == 0) begin
         stall_mode = $urandom_range(0, 2);
         stall_left = $urandom_range(8, 60);
      end else begin
         stall_left--;
      end
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 2) == 0);
         default: rsp_stall <= ($urandom_range(0, 3) != 0);
      endcase
   end

   initial begin
      while (idle_cycles < IDLE_LIMIT) @(posedge clock);
      $display("CHECK FAILED");
      $finish;
   end

   function automatic void queue_request(input request_type r);
      request_backlog.push_back(r);
      pending_requests++;
      queued_total++;
   endfunction

   function automatic request_type random_request();
      request_type r;
      r.command = ($urandom_range(0, 19) == 0) ? CMD_UNUSED : 2'($urandom_range(0, 2));
      r.ack_block = 16'($urandom);
      r.chunk_length = 16'($urandom_range(0, 65464));
      r.client_blksize = 16'($urandom_range(0, 65464));
      r.client_timeout = 8'($urandom);
      r.tsize_present = 1'($urandom);
      r.tsize_nonzero = 1'($urandom);
      r.extra_options = 1'($urandom);
      r.size_known = 1'($urandom);
      r.file_size = $urandom;
      return r;
   endfunction

   function automatic request_type start_req(input logic [15:0] cblk, input logic [7:0] ctmo,
                                             input logic tpres, input logic tnz,
                                             input logic extra, input logic known,
                                             input logic [31:0] fsize,
                                             input logic [15:0] chunk);
      request_type r;
      r = random_request();
      r.command = CMD_START;
      r.client_blksize = cblk;
      r.client_timeout = ctmo;
      r.tsize_present = tpres;
      r.tsize_nonzero = tnz;
      r.extra_options = extra;
      r.size_known = known;
      r.file_size = fsize;
      r.chunk_length = chunk;
      return r;
   endfunction

   function automatic request_type ack_req(input logic [15:0] blk, input logic [15:0] chunk);
      request_type r;
      r = random_request();
      r.command = CMD_ACK;
      r.ack_block = blk;
      r.chunk_length = chunk;
      return r;
   endfunction

   function automatic request_type cmd_req(input logic [1:0] cmd);
      request_type r;
      r = random_request();
      r.command = cmd;
      return r;
   endfunction

   // A maximal or random chunk length until the last block, which gets 0 to 7.
   function automatic logic [15:0] chunk_for(input int block, input int blocks);
      if (block >= blocks) return 16'($urandom_range(0, 7));
      return ($urandom_range(0, 1) != 0) ? CHUNK_MAX : 16'($urandom_range(0, 65464));
   endfunction

   // A read transfer that mostly follows the protocol, with the odd repeat, wrong
   // block number, stray packet or abandoned transfer.
   function automatic void queue_transfer();
      int          blocks;
      int          k;
      logic [15:0] cblk;
      logic [7:0]  ctmo;
      blocks = $urandom_range(1, 6);
      case ($urandom_range(0, 3))
         0: cblk = '0;
         1: cblk = 16'($urandom_range(1, 64));
         default: cblk = 16'($urandom_range(1, 65464));
      endcase
      ctmo = ($urandom_range(0, 2) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
      if ($urandom_range(0, 3) == 0)
         queue_request(start_req('0, '0, 1'b0, 1'($urandom), 1'b0, 1'($urandom), $urandom,
                                 chunk_for(1, blocks)));
      else
         queue_request(start_req(cblk, ctmo, 1'($urandom), ($urandom_range(0, 3) == 0),
                                 ($urandom_range(0, 3) == 0), 1'($urandom), $urandom,
                                 chunk_for(1, blocks)));
      for (k = 0; k <= blocks; k++) begin
         case ($urandom_range(0, 19))
            0: queue_request(ack_req(16'(k - 1), chunk_for(k, blocks)));
            1: begin
               queue_request(ack_req(16'(k + $urandom_range(2, 300)), chunk_for(k, blocks)));
               break;
            end
            2: begin
               queue_request(cmd_req(CMD_DATA));
               break;
            end
            3: queue_request(cmd_req(CMD_UNUSED));
            4: break;
            default: ;
         endcase
         queue_request(ack_req(16'(k), chunk_for(k + 1, blocks)));
      end
   endfunction

   task automatic csr_transfer(input logic write, input logic [1:0] index,
                               input logic [31:0] wdata, output logic [31:0] rdata);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= write;
      csr_paddr <= {index, 2'b00};
      csr_pwdata <= wdata;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      rdata = csr_prdata;
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   task automatic check_reg(input logic [1:0] index, input logic [31:0] want);
      logic [31:0] rdata;
      csr_transfer(1'b0, index, '0, rdata);
      if (rdata !== want) report_mismatch("register read", rdata, want);
   endtask

   task automatic set_reg(input logic [1:0] index, input logic [31:0] value);
      logic [31:0] rdata;
      csr_transfer(1'b1, index, value, rdata);
      case (index)
         REG_MAX_BLOCK_SIZE: cfg_shadow.max_block_size = value[15:0];
         REG_TIMEOUT_LIMIT: cfg_shadow.timeout_limit = value[7:0];
         REG_TSIZE_ENABLE: cfg_shadow.tsize_enable = value[0];
         default: cfg_shadow.default_block_size = value[15:0];
      endcase
      check_reg(index, value);
   endtask

   task automatic configure(input logic [15:0] max_size, input logic [7:0] tmo_limit,
                            input logic tsize_on, input logic [15:0] dflt_size);
      set_reg(REG_MAX_BLOCK_SIZE, 32'(max_size));
      set_reg(REG_TIMEOUT_LIMIT, 32'(tmo_limit));
      set_reg(REG_TSIZE_ENABLE, 32'(tsize_on));
      set_reg(REG_DEFAULT_BLOCK_SIZE, 32'(dflt_size));
   endtask

   task automatic wait_drained();
      while (pending_requests != 0 || awaited_packets.size() != 0) @(posedge clock);
   endtask

   task automatic random_phase(input int items);
      int          first;
      logic [15:0] max_size;
      logic [7:0]  tmo_limit;
      logic [15:0] dflt_size;
      case ($urandom_range(0, 3))
         0: max_size = '0;
         1: max_size = CHUNK_MAX;
         2: max_size = 16'($urandom_range(1, 64));
         default: max_size = 16'($urandom_range(1, 65464));
      endcase
      case ($urandom_range(0, 2))
         0: tmo_limit = '0;
         1: tmo_limit = 8'd255;
         default: tmo_limit = 8'($urandom_range(1, 254));
      endcase
      case ($urandom_range(0, 3))
         0: dflt_size = 16'd8;
         1: dflt_size = CHUNK_MAX;
         2: dflt_size = DEFAULT_BLOCK_SIZE_RESET;
         default: dflt_size = 16'($urandom_range(8, 65464));
      endcase
      configure(max_size, tmo_limit, 1'($urandom), dflt_size);
      first = queued_total;
      while (queued_total - first < items) begin
         if ($urandom_range(0, 4) == 0) queue_request(random_request());
         else queue_transfer();
      end
      wait_drained();
   endtask

   initial begin
      int k;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      check_reg(REG_MAX_BLOCK_SIZE, '0);
      check_reg(REG_TIMEOUT_LIMIT, '0);
      check_reg(REG_TSIZE_ENABLE, '0);
      check_reg(REG_DEFAULT_BLOCK_SIZE, 32'(DEFAULT_BLOCK_SIZE_RESET));

      // Registers at reset: packets before any start, a plain transfer to its end,
      // packets after the end, and options that nothing is configured to accept.
      queue_request(ack_req('0, '0));
      queue_request(cmd_req(CMD_DATA));
      queue_request(start_req('0, '0, 1'b0, 1'b0, 1'b0, 1'b0, '0, CHUNK_MAX));
      queue_request(ack_req(16'd0, CHUNK_MAX));
      queue_request(ack_req(16'd1, 16'd511));
      queue_request(ack_req(16'd2, '0));
      queue_request(cmd_req(CMD_DATA));
      queue_request(cmd_req(CMD_UNUSED));
      queue_request(start_req(CHUNK_MAX, 8'd255, 1'b1, 1'b1, 1'b0, 1'b1, '1, '0));
      queue_request(ack_req(16'd1, CHUNK_MAX));
      wait_drained();

      // Every option at its widest, a wrong block number and a refused tsize.
      configure(CHUNK_MAX, 8'd255, 1'b1, 16'd8);
      queue_request(start_req(CHUNK_MAX, 8'd255, 1'b1, 1'b0, 1'b1, 1'b1, '1, '0));
      queue_request(ack_req(16'd0, CHUNK_MAX));
      queue_request(ack_req(BLOCK_ALL_ONES, CHUNK_MAX));
      queue_request(start_req(16'd100, '0, 1'b1, 1'b1, 1'b0, 1'b1, 32'd1234, CHUNK_MAX));
      queue_request(start_req(16'd1, 8'd1, 1'b1, 1'b0, 1'b0, 1'b0, '1, CHUNK_MAX));
      queue_request(ack_req(16'd0, '0));
      queue_request(ack_req(16'd0, '0));
      queue_request(ack_req(16'd1, '0));
      queue_request(start_req('0, '0, 1'b0, 1'b0, 1'b0, 1'b0, '0, 16'd3));
      queue_request(cmd_req(CMD_UNUSED));
      queue_request(cmd_req(CMD_DATA));
      wait_drained();

      // Limits that clip the client: blksize above the limit, timeout one above it,
      // and a restart in the middle of a transfer.
      configure(16'd100, 8'd10, 1'b1, CHUNK_MAX);
      queue_request(start_req(16'd200, 8'd11, 1'b0, 1'b0, 1'b0, 1'b0, '0, CHUNK_MAX));
      queue_request(start_req('0, 8'd10, 1'b0, 1'b0, 1'b0, 1'b0, '0, CHUNK_MAX));
      queue_request(start_req('0, 8'd11, 1'b1, 1'b0, 1'b0, 1'b0, '1, CHUNK_MAX));
      queue_request(ack_req(16'd1, 16'd65463));
      queue_request(start_req('0, '0, 1'b1, 1'b0, 1'b0, 1'b1, '0, CHUNK_MAX));
      wait_drained();

      // With a block size of zero no block is short, so even empty chunks keep the
      // transfer running until a wrong block number ends it.
      configure('0, '0, 1'b0, '0);
      queue_request(start_req('0, '0, 1'b0, 1'b0, 1'b0, 1'b0, '0, CHUNK_MAX));
      for (k = 1; k <= 6; k++)
         queue_request(ack_req(16'(k), 16'($urandom_range(0, 7))));
      queue_request(ack_req(16'd3, '0));
      wait_drained();

      repeat (4) random_phase(90);

      repeat (20) @(posedge clock);
      if (awaited_packets.size() != 0)
         report_mismatch("results never delivered", awaited_packets.size(), 0);
      if (mismatch_count == 0) $display("CHECK OK");
      else $display("CHECK FAILED");
      $finish;
   end

endmodule

/* sim.f */
rtl/tftprd_pkg.sv
rtl/tftprd_csr.sv
rtl/tftprd_front.sv
rtl/tftprd_queue.sv
rtl/tftprd_back.sv
rtl/tftp_read_transfer_sender.sv
sim/testbench.sv
